// ----- hdl/cfbm_pkg.sv -----
// ----------------------------------------------------------------------------
// cfbm_pkg
// Types and constants shared by the capture frequency band mapper modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cfbm_pkg;

	localparam int unsigned CAP_W   = 16;
	localparam int unsigned FREQ_W  = 27;
	localparam int unsigned LOWF_W  = 26;
	localparam int unsigned STEP_W  = 20;
	localparam int unsigned TOL_W   = 20;
	localparam int unsigned POS_W   = 10;
	localparam int unsigned CFG_W   = 27;
	localparam int unsigned CFG_IDX_W = 3;
	// Threshold accumulator: a frequency plus the calibration tolerance needs one bit more.
	localparam int unsigned ACC_W   = FREQ_W + 1;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_REF_CLOCK_HZ     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOWEST_FREQUENCY = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_STEP        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CALIB_TOLERANCE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_POS_MUTE         = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_POS_LEVEL_ONE    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_POS_LEVEL_TWO    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_POS_LEVEL_THREE  = 3'd7;

	// Reset values of the registers.
	localparam logic [FREQ_W-1:0] RST_REF_CLOCK_HZ     = 27'd72000000;
	localparam logic [LOWF_W-1:0] RST_LOWEST_FREQUENCY = 26'd10000;
	localparam logic [STEP_W-1:0] RST_BAND_STEP        = 20'd600;
	localparam logic [TOL_W-1:0]  RST_CALIB_TOLERANCE  = 20'd300;
	localparam logic [POS_W-1:0]  RST_POS_MUTE         = 10'd40;
	localparam logic [POS_W-1:0]  RST_POS_LEVEL_ONE    = 10'd25;
	localparam logic [POS_W-1:0]  RST_POS_LEVEL_TWO    = 10'd28;
	localparam logic [POS_W-1:0]  RST_POS_LEVEL_THREE  = 10'd31;

	typedef struct packed {
		logic [CAP_W-1:0] capture_value;
		logic             calibrate_mode;
	} cap_item_t;

	typedef struct packed {
		logic [FREQ_W-1:0] frequency_hz;
		logic [POS_W-1:0]  servo_position;
		logic              in_tolerance;
	} res_item_t;

	// Settings used by the band classifier.
	typedef struct packed {
		logic [LOWF_W-1:0] lowest_frequency;
		logic [STEP_W-1:0] band_step;
		logic [TOL_W-1:0]  calib_tolerance;
		logic [POS_W-1:0]  pos_mute;
		logic [POS_W-1:0]  pos_level_one;
		logic [POS_W-1:0]  pos_level_two;
		logic [POS_W-1:0]  pos_level_three;
	} band_cfg_t;

	// Outcome of one classification.
	typedef struct packed {
		logic             upd;
		logic [POS_W-1:0] pos;
		logic             hit;
	} band_res_t;

endpackage

`default_nettype wire

// ----- hdl/cfbm_divider.sv -----
// ----------------------------------------------------------------------------
// cfbm_divider
// Bit-serial restoring divider: one quotient bit per clock cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cfbm_divider import cfbm_pkg::*; #(
	parameter int unsigned DIVISOR_W = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [FREQ_W-1:0]    dividend,
	input  wire logic [DIVISOR_W-1:0] divisor,
	output logic                      done,
	output logic [FREQ_W-1:0]         quotient
);

	localparam int unsigned CNT_W = $clog2(FREQ_W);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(FREQ_W - 1);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [DIVISOR_W-1:0] d_q;
	logic [FREQ_W-1:0]    nq_q;

	logic [DIVISOR_W:0]   rem_sh;
	logic [DIVISOR_W:0]   rem_sub;
	logic                 ge;
	logic [DIVISOR_W-1:0] rem_nxt;

	// The dividend leaves at the top of nq_q while quotient bits enter at the bottom.
	assign rem_sh  = {rem_q, nq_q[FREQ_W-1]};
	assign ge      = rem_sh >= {1'b0, d_q};
	assign rem_sub = rem_sh - {1'b0, d_q};
	assign rem_nxt = ge ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			d_q    <= '0;
			nq_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= '0;
				d_q    <= divisor;
				nq_q   <= dividend;
			end else if (busy_q) begin
				rem_q <= rem_nxt;
				nq_q  <= {nq_q[FREQ_W-2:0], ge};
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = nq_q;

endmodule

`default_nettype wire

// ----- hdl/cfbm_band.sv -----
// ----------------------------------------------------------------------------
// cfbm_band
// Sequential band classifier and calibration window check.
// ----------------------------------------------------------------------------
`default_nettype none

module cfbm_band import cfbm_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [FREQ_W-1:0] freq,
	input  wire logic              calib,
	input  wire band_cfg_t         cfg,
	output logic                   done,
	output band_res_t              res
);

	localparam logic [2:0] K_BASE = 3'd0;
	localparam logic [2:0] K_LAST = 3'd4;

	logic              busy_q;
	logic              done_q;
	logic              calib_q;
	logic              lo_q;
	logic [2:0]        k_q;
	logic [FREQ_W-1:0] f_q;
	logic [ACC_W-1:0]  acc_q;
	band_res_t         res_q;

	logic [ACC_W-1:0]  f_ext;
	logic [STEP_W-1:0] addend;
	logic [ACC_W-1:0]  sum;
	logic              lo_chk;
	logic              hi_ok;
	logic [POS_W-1:0]  level_pos;

	assign f_ext  = {1'b0, f_q};
	assign addend = calib_q ? cfg.calib_tolerance : cfg.band_step;
	assign sum    = acc_q + ACC_W'(addend);
	// A lower limit below zero counts as no limit, so compare f plus tolerance instead.
	assign lo_chk = (f_ext + ACC_W'(cfg.calib_tolerance)) >= ACC_W'(cfg.lowest_frequency);
	assign hi_ok  = f_ext <= acc_q;

	always_comb begin
		unique case (k_q)
			3'd2:    level_pos = cfg.pos_level_one;
			3'd3:    level_pos = cfg.pos_level_two;
			3'd4:    level_pos = cfg.pos_level_three;
			default: level_pos = cfg.pos_mute;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			calib_q <= 1'b0;
			lo_q    <= 1'b0;
			k_q     <= K_BASE;
			f_q     <= '0;
			acc_q   <= '0;
			res_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				calib_q <= calib;
				k_q     <= K_BASE;
				f_q     <= freq;
				acc_q   <= ACC_W'(cfg.lowest_frequency);
			end else if (busy_q) begin
				if (calib_q) begin
					if (k_q == K_BASE) begin
						lo_q  <= lo_chk;
						acc_q <= sum;
						k_q   <= k_q + 1'b1;
					end else begin
						busy_q    <= 1'b0;
						done_q    <= 1'b1;
						res_q.upd <= lo_q && hi_ok;
						res_q.pos <= cfg.pos_mute;
						res_q.hit <= lo_q && hi_ok;
					end
				end else begin
					if (k_q == K_BASE) begin
						if (f_ext < acc_q) begin
							busy_q    <= 1'b0;
							done_q    <= 1'b1;
							res_q.upd <= 1'b0;
							res_q.pos <= cfg.pos_mute;
							res_q.hit <= 1'b0;
						end else begin
							acc_q <= sum;
							k_q   <= k_q + 1'b1;
						end
					end else if (hi_ok || k_q == K_LAST) begin
						busy_q    <= 1'b0;
						done_q    <= 1'b1;
						res_q.upd <= hi_ok;
						res_q.pos <= level_pos;
						res_q.hit <= 1'b0;
					end else begin
						acc_q <= sum;
						k_q   <= k_q + 1'b1;
					end
				end
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

`default_nettype wire

// ----- hdl/capture_frequency_band_mapper.sv -----
// ----------------------------------------------------------------------------
// capture_frequency_band_mapper
// Measures frequency from pairs of capture values and maps it to a servo position.
// ----------------------------------------------------------------------------
// Each transfer on the capture channel carries one counter value latched at a
// rising edge. Edges are taken in pairs: the first edge of a pair is stored
// and gives no result, and the capture channel stays open. The closing edge
// gives the period as the difference modulo 2^COUNTER_BITS (a zero difference
// reuses the previous period, and with no period since reset the frequency is
// 0), and the reference clock rate is divided by it in a bit-serial restoring
// divider that produces one quotient bit per cycle. A short sequencer then
// compares the frequency against one threshold per cycle: in play mode it
// walks the four bands above the lowest frequency and selects the servo
// position (outside the bands the position is held), and in calibrate mode it
// checks the tolerance window and sets the silence position on a hit. From the
// transfer of a pair's closing edge the capture channel stays closed while the divider
// and the sequencer run and while the previous result is still waiting for its
// transfer; the result register parts the two channels, so a new pair may
// start while a result waits.
// Configuration registers must only be written while no measurement is in
// progress.
// ----------------------------------------------------------------------------
`default_nettype none

module capture_frequency_band_mapper import cfbm_pkg::*; #(
	parameter int unsigned COUNTER_BITS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// capture channel
	input  wire logic                 cap_valid,
	output logic                      cap_stall,
	input  wire cap_item_t            cap_item,
	// result channel
	output logic                      res_valid,
	input  wire logic                 res_stall,
	output res_item_t                 res_item,
	// configuration
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_wdata
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_CLASS,
		ST_WAIT
	} state_t;

	state_t                  state_q;
	logic                    edge_pending_q;
	logic [COUNTER_BITS-1:0] first_edge_q;
	logic [COUNTER_BITS-1:0] last_period_q;
	logic [COUNTER_BITS-1:0] divisor_q;
	logic                    zero_q;
	logic                    calib_q;
	logic                    div_start_q;
	logic                    band_start_q;
	logic [FREQ_W-1:0]       freq_q;
	logic [POS_W-1:0]        held_q;
	logic                    hit_q;
	logic                    res_valid_q;
	res_item_t               res_item_q;

	logic [FREQ_W-1:0]       ref_clock_q;
	band_cfg_t               band_cfg_q;

	logic [COUNTER_BITS-1:0] cap_ext;
	logic [COUNTER_BITS-1:0] diff;
	logic                    cap_xfer;
	logic                    div_done;
	logic [FREQ_W-1:0]       quotient;
	logic                    band_done;
	band_res_t               band_res;

	// Narrow counters keep only their own bits of the capture; wide ones see it zero-extended.
	generate
		if (COUNTER_BITS <= CAP_W) begin : g_cap_narrow
			assign cap_ext = cap_item.capture_value[COUNTER_BITS-1:0];
		end else begin : g_cap_wide
			assign cap_ext = {{(COUNTER_BITS-CAP_W){1'b0}}, cap_item.capture_value};
		end
	endgenerate

	assign diff      = cap_ext - first_edge_q;
	assign cap_stall = (state_q != ST_IDLE);
	assign cap_xfer  = cap_valid && !cap_stall;

	// Configuration registers, truncated to their own widths.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_clock_q                <= RST_REF_CLOCK_HZ;
			band_cfg_q.lowest_frequency <= RST_LOWEST_FREQUENCY;
			band_cfg_q.band_step       <= RST_BAND_STEP;
			band_cfg_q.calib_tolerance <= RST_CALIB_TOLERANCE;
			band_cfg_q.pos_mute        <= RST_POS_MUTE;
			band_cfg_q.pos_level_one   <= RST_POS_LEVEL_ONE;
			band_cfg_q.pos_level_two   <= RST_POS_LEVEL_TWO;
			band_cfg_q.pos_level_three <= RST_POS_LEVEL_THREE;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_REF_CLOCK_HZ:     ref_clock_q <= cfg_wdata[FREQ_W-1:0];
				REG_LOWEST_FREQUENCY: band_cfg_q.lowest_frequency <= cfg_wdata[LOWF_W-1:0];
				REG_BAND_STEP:        band_cfg_q.band_step <= cfg_wdata[STEP_W-1:0];
				REG_CALIB_TOLERANCE:  band_cfg_q.calib_tolerance <= cfg_wdata[TOL_W-1:0];
				REG_POS_MUTE:         band_cfg_q.pos_mute <= cfg_wdata[POS_W-1:0];
				REG_POS_LEVEL_ONE:    band_cfg_q.pos_level_one <= cfg_wdata[POS_W-1:0];
				REG_POS_LEVEL_TWO:    band_cfg_q.pos_level_two <= cfg_wdata[POS_W-1:0];
				REG_POS_LEVEL_THREE:  band_cfg_q.pos_level_three <= cfg_wdata[POS_W-1:0];
				default: ;
			endcase
		end
	end

	// Measurement sequencer and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			edge_pending_q <= 1'b0;
			first_edge_q   <= '0;
			last_period_q  <= '0;
			divisor_q      <= '0;
			zero_q         <= 1'b0;
			calib_q        <= 1'b0;
			div_start_q    <= 1'b0;
			band_start_q   <= 1'b0;
			freq_q         <= '0;
			held_q         <= RST_POS_MUTE;
			hit_q          <= 1'b0;
			res_valid_q    <= 1'b0;
			res_item_q     <= '0;
		end else begin
			div_start_q  <= 1'b0;
			band_start_q <= 1'b0;
			if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cap_xfer) begin
						if (!edge_pending_q) begin
							first_edge_q   <= cap_ext;
							edge_pending_q <= 1'b1;
						end else begin
							edge_pending_q <= 1'b0;
							if (diff != '0) begin
								last_period_q <= diff;
								divisor_q     <= diff;
							end else begin
								divisor_q <= last_period_q;
							end
							zero_q      <= (diff == '0) && (last_period_q == '0);
							calib_q     <= cap_item.calibrate_mode;
							div_start_q <= 1'b1;
							state_q     <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						freq_q       <= zero_q ? '0 : quotient;
						band_start_q <= 1'b1;
						state_q      <= ST_CLASS;
					end
				end
				ST_CLASS: begin
					if (band_done) begin
						if (band_res.upd) begin
							held_q <= band_res.pos;
						end
						hit_q   <= band_res.hit;
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (!res_valid_q || !res_stall) begin
						res_valid_q                <= 1'b1;
						res_item_q.frequency_hz    <= freq_q;
						res_item_q.servo_position  <= held_q;
						res_item_q.in_tolerance    <= hit_q;
						state_q                    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	cfbm_divider #(
		.DIVISOR_W(COUNTER_BITS)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (ref_clock_q),
		.divisor  (divisor_q),
		.done     (div_done),
		.quotient (quotient)
	);

	cfbm_band u_band (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (band_start_q),
		.freq   (freq_q),
		.calib  (calib_q),
		.cfg    (band_cfg_q),
		.done   (band_done),
		.res    (band_res)
	);

	assign res_valid = res_valid_q;
	assign res_item  = res_item_q;

endmodule

`default_nettype wire

// ----- hdl/cfbm_checker.sv -----
// ----------------------------------------------------------------------------
// cfbm_checker
// Port-level assertions for the capture frequency band mapper.
// ----------------------------------------------------------------------------
`default_nettype none

module cfbm_checker import cfbm_pkg::*; (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 cap_valid,
	input wire logic                 cap_stall,
	input wire cap_item_t            cap_item,
	input wire logic                 res_valid,
	input wire logic                 res_stall,
	input wire res_item_t            res_item
);

	// A stalled capture stays offered and unchanged.
	a_cap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cap_valid && cap_stall |=> cap_valid && $stable(cap_item))
		else $error("capture changed or dropped while stalled");

	// A stalled result stays offered and unchanged.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_item))
		else $error("result changed or dropped while stalled");

	// A result is only withdrawn by a completed transfer.
	a_res_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(res_valid) |-> $past(!res_stall))
		else $error("result withdrawn without a transfer");

	// The capture channel closes only just after a capture transfer.
	a_stall_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(cap_stall) |-> $past(cap_valid))
		else $error("capture stall rose without a capture transfer");

	// A new result appears only after a measurement held the capture channel closed.
	a_res_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(cap_stall))
		else $error("result appeared without a measurement");

endmodule

bind capture_frequency_band_mapper cfbm_checker u_cfbm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cap_valid (cap_valid),
	.cap_stall (cap_stall),
	.cap_item  (cap_item),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res_item  (res_item)
);

`default_nettype wire
